/* design/tegc_pkg.sv */
// ============================================================================
// tegc_pkg
// Shared types and constants for the touch event to gesture command block.
// ============================================================================
package tegc_pkg;

    localparam int COORD_W = 17;
    localparam int TIME_W  = 26;
    localparam int DELAY_W = 27;
    localparam int CFG_W   = 26;
    localparam int CFG_A_W = 3;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 64;

    localparam logic [COORD_W-1:0] COORD_NONE = '1;
    localparam logic [COORD_W-1:0] COORD_MAX  = 17'h0FFFF;

    localparam logic [15:0] TYPE_SYNC = 16'd0;
    localparam logic [15:0] TYPE_KEY  = 16'd1;
    localparam logic [15:0] TYPE_ABS  = 16'd3;

    localparam logic [15:0] CODE_SYNC  = 16'd0;
    localparam logic [15:0] CODE_X     = 16'd53;
    localparam logic [15:0] CODE_Y     = 16'd54;
    localparam logic [15:0] CODE_TRKID = 16'd57;
    localparam logic [15:0] CODE_TOUCH = 16'd330;

    localparam logic [CFG_A_W-1:0] REG_SCREEN_W = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_SCREEN_H = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_PANEL_X  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_PANEL_Y  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_START_T  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_REC_EN   = 3'd5;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_DOWN = 2'd1;
    localparam logic [1:0] CMD_MOVE = 2'd2;
    localparam logic [1:0] CMD_UP   = 2'd3;

    localparam int DIV_STEPS = 16;

    typedef enum logic [2:0] {
        EV_OTHER,
        EV_X,
        EV_Y,
        EV_TOUCH,
        EV_RELEASE,
        EV_SYNC
    } ev_kind_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic prep;
        logic step;
        logic store;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic     rec_en;
        ev_kind_t kind;
        logic     out_free;
    } dp_status_t;

endpackage

/* design/tegc_ctrl.sv */
// ============================================================================
// tegc_ctrl
// Sequencer: request acceptance, multiply, divide steps and frame close.
// ============================================================================
module tegc_ctrl
    import tegc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_STORE,
        S_SYNC
    } state_t;

    localparam int CNT_W = $clog2(DIV_STEPS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.rec_en)
                begin
                    if (status.kind == EV_X || status.kind == EV_Y)
                        state_next = S_MUL;
                    else if (status.kind == EV_SYNC)
                        state_next = S_SYNC;
                end
            end
            S_MUL:
                state_next = S_PREP;
            S_PREP:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_STORE;
            end
            S_STORE:
                state_next = S_IDLE;
            S_SYNC:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.accept = (state_reg == S_IDLE) && in_valid;
    assign cmd.mul    = (state_reg == S_MUL);
    assign cmd.prep   = (state_reg == S_PREP);
    assign cmd.step   = (state_reg == S_DIV);
    assign cmd.store  = (state_reg == S_STORE);
    assign cmd.emit   = (state_reg == S_SYNC) && status.out_free;

endmodule

/* design/tegc_dp.sv */
// ============================================================================
// tegc_dp
// Datapath: config registers, event decode, scaling multiply and restoring
// divider, frame state and result register.
// ============================================================================
module tegc_dp
    import tegc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [IN_W-1:0]    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   out_data,
    input  dp_cmd_t            cmd,
    output dp_status_t         status
);

    typedef enum logic [1:0] {
        FL_NONE,
        FL_TOUCH,
        FL_RELEASE
    } flag_t;

    logic [15:0]         ev_type, ev_code;
    logic [31:0]         ev_value;
    logic [TIME_W-1:0]   ev_time;
    ev_kind_t            kind;

    logic [15:0]         scr_w_reg, scr_h_reg, pan_x_reg, pan_y_reg;
    logic                rec_en_reg;
    logic [TIME_W-1:0]   last_t_reg;

    logic [COORD_W-1:0]  frame_x_reg, frame_y_reg, prev_x_reg, prev_y_reg;
    flag_t               flag_reg;
    logic                touching_reg, down_pend_reg;

    logic [30:0]         val_reg;
    logic                sel_y_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [46:0]         prod_reg;
    logic [15:0]         rem_reg, low_reg, quot_reg;
    logic                sat_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic [15:0]         num, den;
    logic [16:0]         trial;
    logic                ge;
    logic [COORD_W-1:0]  coord;

    logic                kx, ky, touch_n, pend_n, dvalid;
    logic [COORD_W-1:0]  px_n, py_n, x2, y2, out_x, out_y;
    logic [1:0]          command;
    logic [DELAY_W-1:0]  delay;

    assign ev_type  = in_data[15:0];
    assign ev_code  = in_data[31:16];
    assign ev_value = in_data[63:32];
    assign ev_time  = in_data[89:64];

    always_comb
    begin
        kind = EV_OTHER;
        if (ev_type == TYPE_ABS)
        begin
            if (ev_code == CODE_X)
                kind = EV_X;
            else if (ev_code == CODE_Y)
                kind = EV_Y;
            else if (ev_code == CODE_TRKID)
            begin
                if (!ev_value[31] && ev_value != 32'd0)
                    kind = EV_TOUCH;
                else if (ev_value == 32'hFFFF_FFFF)
                    kind = EV_RELEASE;
            end
        end
        else if (ev_type == TYPE_KEY && ev_code == CODE_TOUCH)
        begin
            if (ev_value == 32'd1)
                kind = EV_TOUCH;
            else if (ev_value == 32'd0)
                kind = EV_RELEASE;
        end
        else if (ev_type == TYPE_SYNC && ev_code == CODE_SYNC && ev_value == 32'd0)
            kind = EV_SYNC;
    end

    assign status.rec_en   = rec_en_reg;
    assign status.kind     = kind;
    assign status.out_free = !out_valid_reg || out_ready;

    // scaling: multiply, then 16 quotient bits one per cycle
    assign num   = sel_y_reg ? scr_h_reg : scr_w_reg;
    assign den   = sel_y_reg ? pan_y_reg : pan_x_reg;
    assign trial = {rem_reg, low_reg[15]};
    assign ge    = (trial >= {1'b0, den});
    assign coord = (den == 16'd0 || sat_reg) ? COORD_MAX : {1'b0, quot_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            val_reg   <= ev_value[31] ? 31'd0 : ev_value[30:0];
            sel_y_reg <= (kind == EV_Y);
            time_reg  <= ev_time;
        end
        if (cmd.mul)
            prod_reg <= val_reg * num;
        if (cmd.prep)
        begin
            sat_reg <= (prod_reg[46:16] >= {15'd0, den});
            rem_reg <= prod_reg[31:16];
            low_reg <= prod_reg[15:0];
        end
        if (cmd.step)
        begin
            rem_reg  <= ge ? 16'(trial - {1'b0, den}) : trial[15:0];
            low_reg  <= {low_reg[14:0], 1'b0};
            quot_reg <= {quot_reg[14:0], ge};
        end
        if (cmd.emit)
            out_data_reg <= {out_y, out_x, command, delay, dvalid};
    end

    // frame close
    always_comb
    begin
        kx      = (frame_x_reg != COORD_NONE);
        ky      = (frame_y_reg != COORD_NONE);
        px_n    = kx ? frame_x_reg : prev_x_reg;
        py_n    = ky ? frame_y_reg : prev_y_reg;
        touch_n = touching_reg;
        pend_n  = down_pend_reg;
        if (flag_reg == FL_TOUCH)
        begin
            touch_n = 1'b1;
            pend_n  = 1'b1;
        end
        else if (flag_reg == FL_RELEASE)
        begin
            touch_n = 1'b0;
            pend_n  = 1'b0;
        end
        x2 = frame_x_reg;
        y2 = frame_y_reg;
        if (!kx && ky)
            x2 = px_n;
        else if (kx && !ky)
            y2 = py_n;
        command = CMD_NONE;
        out_x   = COORD_NONE;
        out_y   = COORD_NONE;
        if (touch_n && pend_n)
        begin
            command = CMD_DOWN;
            out_x   = x2;
            out_y   = y2;
            pend_n  = 1'b0;
        end
        else if (touch_n)
        begin
            if (x2 != COORD_NONE && y2 != COORD_NONE)
            begin
                command = CMD_MOVE;
                out_x   = x2;
                out_y   = y2;
            end
        end
        else if (!pend_n && px_n != COORD_NONE && py_n != COORD_NONE)
        begin
            command = CMD_UP;
            out_x   = px_n;
            out_y   = py_n;
        end
        dvalid = (last_t_reg != '0);
        delay  = dvalid ? ({1'b0, time_reg} - {1'b0, last_t_reg}) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg     <= 16'd768;
            scr_h_reg     <= 16'd1280;
            pan_x_reg     <= 16'd4095;
            pan_y_reg     <= 16'd4095;
            rec_en_reg    <= 1'b0;
            last_t_reg    <= '0;
            frame_x_reg   <= COORD_NONE;
            frame_y_reg   <= COORD_NONE;
            prev_x_reg    <= COORD_NONE;
            prev_y_reg    <= COORD_NONE;
            flag_reg      <= FL_NONE;
            touching_reg  <= 1'b0;
            down_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SCREEN_W: scr_w_reg  <= cfg_data[15:0];
                    REG_SCREEN_H: scr_h_reg  <= cfg_data[15:0];
                    REG_PANEL_X:  pan_x_reg  <= cfg_data[15:0];
                    REG_PANEL_Y:  pan_y_reg  <= cfg_data[15:0];
                    REG_START_T:  last_t_reg <= cfg_data[TIME_W-1:0];
                    REG_REC_EN:   rec_en_reg <= cfg_data[0];
                    default:      ;
                endcase
            end
            if (cmd.accept && rec_en_reg)
            begin
                if (kind == EV_TOUCH)
                    flag_reg <= FL_TOUCH;
                else if (kind == EV_RELEASE)
                    flag_reg <= FL_RELEASE;
            end
            if (cmd.store)
            begin
                if (sel_y_reg)
                    frame_y_reg <= coord;
                else
                    frame_x_reg <= coord;
            end
            if (cmd.emit)
            begin
                prev_x_reg    <= px_n;
                prev_y_reg    <= py_n;
                touching_reg  <= touch_n;
                down_pend_reg <= pend_n;
                last_t_reg    <= time_reg;
                frame_x_reg   <= COORD_NONE;
                frame_y_reg   <= COORD_NONE;
                flag_reg      <= FL_NONE;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/touch_event_to_gesture_command.sv */
// ============================================================================
// touch_event_to_gesture_command
// Turns raw multitouch events into down, move and up commands (or none) with
// scaled screen coordinates and the delay between frames.
// ============================================================================
// An X/Y event occupies the block through multiply, prep, the 16 divide steps
// and store; flag and ignored events are taken in the idle state alone; a sync
// waits in the sync state until the output register is free, then loads it.
// No new request is taken until an X/Y event has finished its divide and store.
// Reset (rst_n, async, active low) clears frame state and restores config.
module touch_event_to_gesture_command
    import tegc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    // event_type[15:0], event_code[31:16], event_value[63:32], time_ms[89:64]
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // delay_valid[0], delay_ms[27:1], command[29:28], point_x[46:30],
    // point_y[63:47]
    output logic [OUT_W-1:0]   m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tegc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tegc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    a_none_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[29:28] == CMD_NONE
        |-> m_tdata[46:30] == COORD_NONE && m_tdata[63:47] == COORD_NONE)
        else $error("command none carries a point");

    a_no_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[27:1] == '0)
        else $error("delay reported without time base");

    a_coord_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && status.rec_en && (status.kind == EV_X || status.kind == EV_Y)
        |=> !s_tready)
        else $error("coordinate request did not occupy the divider");

endmodule
